>>> src/ilp_pkg.sv
// shared types and character constants of the integer literal parser
package ilp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;
  // magnitude times base before truncation: base is at most 16
  localparam int unsigned WIDE_W  = VALUE_W + 4;

  localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_1 = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_7 = 8'h37;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_UNDER   = 8'h5F;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_O       = 8'h6F;
  localparam logic [CHAR_W-1:0] CHAR_B       = 8'h62;

  localparam logic ERR_NONE     = 1'b0;
  localparam logic ERR_NO_DIGIT = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error_code;
    logic               overflowed;
    logic [CHAR_W-1:0]  stop_char;
    logic               stop_is_end;
  } result_t;

endpackage

>>> src/integer_literal_parser.sv
// top level of the streaming integer literal parser
//
//   channel | direction | transaction carries
//   --------+-----------+------------------------------------------------------
//   in_     | input     | text_char, end_of_text (one character or end of text)
//   out_    | output    | value, error_code, overflowed, stop_char, stop_is_end
//
// one character per cycle sustained while the result side is not stalled; the
// transaction that ends a token passes the input register, then the result register
// the per-character loop is the token state update: multiply by base, add digit
// and overflow compare, all combinational between the two registers
// synchronous active-low reset returns to the start of a token, both registers empty
// a stalled result register holds the character in the input register, which
// then raises in_stall; an unstalled or empty result register never stalls input
module integer_literal_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ilp_pkg::CHAR_W-1:0]   in_text_char,
  input  logic                         in_end_of_text,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ilp_pkg::VALUE_W-1:0]  out_value,
  output logic                         out_error_code,
  output logic                         out_overflowed,
  output logic [ilp_pkg::CHAR_W-1:0]   out_stop_char,
  output logic                         out_stop_is_end
);

  // input register
  logic                        in_v_r, in_v_nxt;
  logic [ilp_pkg::CHAR_W-1:0]  in_char_r;
  logic                        in_eot_r;
  logic                        in_take;

  // result register
  logic                        out_v_r, out_v_nxt;
  ilp_pkg::result_t            out_res_r;

  // step control
  logic                        step_go;
  logic                        step_emit;
  ilp_pkg::result_t            step_res;

  // the held character moves on whenever the result register has room
  assign step_go  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !step_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (step_go) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (step_go && step_emit) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  ilp_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (step_go),
    .text_char   (in_char_r),
    .end_of_text (in_eot_r),
    .emit        (step_emit),
    .result      (step_res)
  );

  // control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload flops, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r <= in_text_char;
      in_eot_r  <= in_end_of_text;
    end
    if (step_go && step_emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid       = out_v_r;
  assign out_value       = out_res_r.value;
  assign out_error_code  = out_res_r.error_code;
  assign out_overflowed  = out_res_r.overflowed;
  assign out_stop_char   = out_res_r.stop_char;
  assign out_stop_is_end = out_res_r.stop_is_end;

endmodule

>>> src/ilp_step.sv
// token state of the parser and its per-character update
module ilp_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [ilp_pkg::CHAR_W-1:0]   text_char,
  input  logic                         end_of_text,
  output logic                         emit,
  output ilp_pkg::result_t             result
);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ZERO  = 3'd1,
    PH_SIGN  = 3'd2,
    PH_DEC   = 3'd3,
    PH_HEX   = 3'd4,
    PH_OCT   = 3'd5,
    PH_BIN   = 3'd6
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [ilp_pkg::VALUE_W-1:0]     acc_r, acc_nxt;
  logic                            neg_r, neg_nxt;
  logic                            ovf_r, ovf_nxt;

  logic                            is_dec, is_hex_lo, is_hex_up;
  logic [3:0]                      dig;
  logic                            dig_ok;
  logic [ilp_pkg::WIDE_W-1:0]      acc_w, scaled, sum_w, limit_w;
  logic                            err;
  logic [ilp_pkg::VALUE_W-1:0]     mag;

  // digit value of the character in the current base
  always_comb begin
    is_dec    = (text_char >= ilp_pkg::CHAR_DIGIT_0) && (text_char <= ilp_pkg::CHAR_DIGIT_9);
    is_hex_lo = (text_char >= ilp_pkg::CHAR_LOWER_A) && (text_char <= ilp_pkg::CHAR_LOWER_F);
    is_hex_up = (text_char >= ilp_pkg::CHAR_UPPER_A) && (text_char <= ilp_pkg::CHAR_UPPER_F);
    priority if (is_dec) begin
      dig = 4'(text_char - ilp_pkg::CHAR_DIGIT_0);
    end else if (is_hex_lo) begin
      dig = 4'(text_char - ilp_pkg::CHAR_LOWER_A + 8'd10);
    end else if (is_hex_up) begin
      dig = 4'(text_char - ilp_pkg::CHAR_UPPER_A + 8'd10);
    end else begin
      dig = 4'd0;
    end
    unique case (phase_r)
      PH_HEX:  dig_ok = is_dec || is_hex_lo || is_hex_up;
      PH_OCT:  dig_ok = is_dec && (text_char <= ilp_pkg::CHAR_DIGIT_7);
      PH_BIN:  dig_ok = is_dec && (text_char <= ilp_pkg::CHAR_DIGIT_1);
      default: dig_ok = is_dec;
    endcase
  end

  // magnitude times base by shifts, overflow when the exact sum passes the limit
  always_comb begin
    acc_w = {4'd0, acc_r};
    unique case (phase_r)
      PH_HEX:  scaled = acc_w << 4;
      PH_OCT:  scaled = acc_w << 3;
      PH_BIN:  scaled = acc_w << 1;
      default: scaled = (acc_w << 3) + (acc_w << 1);
    endcase
    sum_w   = scaled + {{(ilp_pkg::WIDE_W-4){1'b0}}, dig};
    limit_w = {4'd0, neg_r, {(ilp_pkg::VALUE_W-1){~neg_r}}};
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    emit      = 1'b0;
    err       = ilp_pkg::ERR_NONE;
    unique case (phase_r)
      PH_START: begin
        if (end_of_text) begin
          emit = 1'b1;
          err  = ilp_pkg::ERR_NO_DIGIT;
        end else if (text_char == ilp_pkg::CHAR_DIGIT_0) begin
          phase_nxt = PH_ZERO;
        end else if (is_dec) begin
          acc_nxt   = {{(ilp_pkg::VALUE_W-4){1'b0}}, dig};
          phase_nxt = PH_DEC;
        end else begin
          neg_nxt   = (text_char == ilp_pkg::CHAR_MINUS);
          phase_nxt = PH_SIGN;
        end
      end
      PH_ZERO: begin
        if (end_of_text) begin
          emit = 1'b1;
        end else if (text_char == ilp_pkg::CHAR_X) begin
          phase_nxt = PH_HEX;
        end else if (text_char == ilp_pkg::CHAR_O) begin
          phase_nxt = PH_OCT;
        end else if (text_char == ilp_pkg::CHAR_B) begin
          phase_nxt = PH_BIN;
        end else begin
          emit = 1'b1;
        end
      end
      PH_SIGN: begin
        if (!end_of_text && is_dec) begin
          acc_nxt   = {{(ilp_pkg::VALUE_W-4){1'b0}}, dig};
          phase_nxt = PH_DEC;
        end else begin
          emit = 1'b1;
          err  = ilp_pkg::ERR_NO_DIGIT;
        end
      end
      PH_DEC, PH_HEX, PH_OCT, PH_BIN: begin
        if (end_of_text) begin
          emit = 1'b1;
        end else if (text_char == ilp_pkg::CHAR_UNDER) begin
          phase_nxt = phase_r;
        end else if (dig_ok) begin
          acc_nxt = sum_w[ilp_pkg::VALUE_W-1:0];
          ovf_nxt = ovf_r || (sum_w > limit_w);
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_START;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        ovf_nxt   = 1'b0;
      end
    endcase
    // a finished token starts over
    if (emit) begin
      phase_nxt = PH_START;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_comb begin
    mag                = neg_r ? (ilp_pkg::VALUE_W'(0) - acc_r) : acc_r;
    result.value       = (err == ilp_pkg::ERR_NO_DIGIT) ? '0 : mag;
    result.error_code  = err;
    result.overflowed  = (err == ilp_pkg::ERR_NONE) && ovf_r;
    result.stop_char   = end_of_text ? '0 : text_char;
    result.stop_is_end = end_of_text;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (go) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

>>> src/ilp_checker.sv
// port-level checks of the integer literal parser and their binding
module ilp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ilp_pkg::VALUE_W-1:0]  out_value,
  input logic                         out_error_code,
  input logic                         out_overflowed,
  input logic [ilp_pkg::CHAR_W-1:0]   out_stop_char,
  input logic                         out_stop_is_end
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_stop_char)
      && $stable(out_error_code) && $stable(out_overflowed) && $stable(out_stop_is_end))
    else $error("stalled result changed");

  // input backpressure only comes from a full, stalled result side
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without result backpressure");

  // a missing digit carries value zero and no overflow
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code |-> out_value == '0 && !out_overflowed)
    else $error("error result with value or overflow");

  // end of text hands back no character
  a_end_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_is_end |-> out_stop_char == '0)
    else $error("end of text with a stop character");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_value       (out_value),
  .out_error_code  (out_error_code),
  .out_overflowed  (out_overflowed),
  .out_stop_char   (out_stop_char),
  .out_stop_is_end (out_stop_is_end)
);
